// ----- rtl/oss_pkg.sv -----
// Shared types, constants and the operation schedule for the omega stream core.
`timescale 1ns / 1ps
`default_nettype none
package oss_pkg;

  localparam int unsigned NumSteps = 16;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [3:0] SRC_M    = 4'd0;
  localparam logic [3:0] SRC_N    = 4'd1;
  localparam logic [3:0] SRC_L    = 4'd2;
  localparam logic [3:0] SRC_R    = 4'd3;
  localparam logic [3:0] SRC_C    = 4'd4;
  localparam logic [3:0] SRC_ONE  = 4'd5;
  localparam logic [3:0] SRC_TWO  = 4'd6;
  localparam logic [3:0] SRC_BIAS = 4'd7;
  localparam logic [3:0] SRC_SUM  = 4'd8;
  localparam logic [3:0] SRC_T0   = 4'd9;
  localparam logic [3:0] SRC_T1   = 4'd10;
  localparam logic [3:0] SRC_T2   = 4'd11;

  localparam logic [1:0] DST_T0  = 2'd0;
  localparam logic [1:0] DST_T1  = 2'd1;
  localparam logic [1:0] DST_T2  = 2'd2;
  localparam logic [1:0] DST_SUM = 2'd3;

  localparam logic [31:0] F_ZERO = 32'h0000_0000;
  localparam logic [31:0] F_ONE  = 32'h3F80_0000;
  localparam logic [31:0] F_TWO  = 32'h4000_0000;
  localparam logic [31:0] F_BIAS = 32'h3C23_D70A;
  localparam logic [31:0] F_MAX  = 32'h7F7F_FFFF;
  localparam logic [31:0] F_DNAN = 32'hFFC0_0000;
  localparam logic [31:0] F_QBIT = 32'h0040_0000;

  typedef struct packed {
    logic [31:0] m_value;
    logic [31:0] n_value;
    logic [31:0] left_sum;
    logic [31:0] right_sum;
    logic [31:0] total_sum;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [31:0] omega_value;
    logic [31:0] max_value;
    logic [31:0] min_value;
    logic [31:0] sum_value;
    logic        totals_valid;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } fpu_rsp_t;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] a_sel;
    logic [3:0] b_sel;
    logic [1:0] dst;
  } step_t;

  function automatic step_t step_cfg(input logic [3:0] idx);
    step_t s;
    unique case (idx)
      4'd0:  s = '{OP_ADD, SRC_L,  SRC_ONE,  DST_T0};
      4'd1:  s = '{OP_SUB, SRC_M,  SRC_ONE,  DST_T1};
      4'd2:  s = '{OP_MUL, SRC_M,  SRC_T1,   DST_T1};
      4'd3:  s = '{OP_DIV, SRC_T1, SRC_TWO,  DST_T1};
      4'd4:  s = '{OP_SUB, SRC_N,  SRC_ONE,  DST_T2};
      4'd5:  s = '{OP_MUL, SRC_N,  SRC_T2,   DST_T2};
      4'd6:  s = '{OP_DIV, SRC_T2, SRC_TWO,  DST_T2};
      4'd7:  s = '{OP_ADD, SRC_T1, SRC_T2,   DST_T1};
      4'd8:  s = '{OP_DIV, SRC_T0, SRC_T1,   DST_T0};
      4'd9:  s = '{OP_SUB, SRC_C,  SRC_L,    DST_T1};
      4'd10: s = '{OP_SUB, SRC_T1, SRC_R,    DST_T1};
      4'd11: s = '{OP_MUL, SRC_M,  SRC_N,    DST_T2};
      4'd12: s = '{OP_DIV, SRC_T1, SRC_T2,   DST_T1};
      4'd13: s = '{OP_ADD, SRC_T1, SRC_BIAS, DST_T1};
      4'd14: s = '{OP_DIV, SRC_T0, SRC_T1,   DST_T0};
      4'd15: s = '{OP_ADD, SRC_T0, SRC_SUM,  DST_SUM};
      default: s = '{OP_ADD, SRC_T0, SRC_SUM, DST_SUM};
    endcase
    // first step adds right_sum to left_sum
    if (idx == 4'd0) begin
      s.b_sel = SRC_R;
    end
    return s;
  endfunction

  function automatic logic f_gt(input logic [31:0] a, input logic [31:0] b);
    logic        a_nan;
    logic        b_nan;
    logic        both_zero;
    logic [31:0] ka;
    logic [31:0] kb;
    a_nan     = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan     = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    ka        = a[31] ? ~a : (a | 32'h8000_0000);
    kb        = b[31] ? ~b : (b | 32'h8000_0000);
    return !a_nan && !b_nan && !both_zero && (ka > kb);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/oss_fpu.sv -----
// Iterative single-precision add, subtract, multiply and divide unit.
`timescale 1ns / 1ps
`default_nettype none
module oss_fpu (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire oss_pkg::fpu_req_t req_i,
  output oss_pkg::fpu_rsp_t     rsp_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_NORM = 3'd3;
  localparam logic [2:0] S_DEN  = 3'd4;
  localparam logic [2:0] S_PACK = 3'd5;

  logic [2:0]         st_q, st_d;
  logic               done_q, done_d;
  logic [31:0]        res_q, res_d;
  logic               sgn_q, sgn_d;
  logic signed [11:0] ea_q, ea_d, eb_q, eb_d, e_q, e_d;
  logic [23:0]        ma_q, ma_d, mb_q, mb_d;
  logic [25:0]        rem_q, rem_d;
  logic [49:0]        r_q, r_d;
  logic               stk_q, stk_d;
  logic [4:0]         cnt_q, cnt_d;

  logic [31:0]        a, b;
  logic               sa, sb, sx;
  logic [7:0]         xa, xb;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0]        ma, mb;
  logic signed [11:0] eau, ebu;
  logic               spec;
  logic [31:0]        spec_res;

  logic               a_big;
  logic signed [11:0] e_big, e_sm, dexp;
  logic [23:0]        m_big, m_sm;
  logic               s_big, s_sm;
  logic [26:0]        sm_ext, sm_sh, sm_mask, sm_jam;
  logic               sm_lost;
  logic [27:0]        sum28;
  logic [47:0]        prod;

  logic [26:0]        trial;
  logic               qbit;
  logic [25:0]        nrem;
  logic signed [11:0] biased;
  logic [7:0]         expf;
  logic [30:0]        base;
  logic               inc;

  always_comb begin
    a      = req_i.a;
    b      = req_i.b;
    sa     = a[31];
    sb     = b[31] ^ (req_i.op == oss_pkg::OP_SUB);
    sx     = a[31] ^ b[31];
    xa     = a[30:23];
    xb     = b[30:23];
    a_nan  = (xa == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (xb == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (xa == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (xb == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ma     = {xa != 8'd0, a[22:0]};
    mb     = {xb != 8'd0, b[22:0]};
    eau    = (xa == 8'd0) ? -12'sd149 : ($signed({4'd0, xa}) - 12'sd150);
    ebu    = (xb == 8'd0) ? -12'sd149 : ($signed({4'd0, xb}) - 12'sd150);

    spec     = 1'b1;
    spec_res = oss_pkg::F_DNAN;
    if (a_nan) begin
      spec_res = a | oss_pkg::F_QBIT;
    end else if (b_nan) begin
      spec_res = b | oss_pkg::F_QBIT;
    end else begin
      unique case (req_i.op)
        oss_pkg::OP_ADD, oss_pkg::OP_SUB: begin
          if (a_inf && b_inf && (sa != sb)) spec_res = oss_pkg::F_DNAN;
          else if (a_inf) spec_res = a;
          else if (b_inf) spec_res = {sb, b[30:0]};
          else if (a_zero && b_zero) spec_res = {sa & sb, 31'd0};
          else if (a_zero) spec_res = {sb, b[30:0]};
          else if (b_zero) spec_res = a;
          else spec = 1'b0;
        end
        oss_pkg::OP_MUL: begin
          if ((a_inf && b_zero) || (a_zero && b_inf)) spec_res = oss_pkg::F_DNAN;
          else if (a_inf || b_inf) spec_res = {sx, 8'hFF, 23'd0};
          else if (a_zero || b_zero) spec_res = {sx, 31'd0};
          else spec = 1'b0;
        end
        oss_pkg::OP_DIV: begin
          if ((a_inf && b_inf) || (a_zero && b_zero)) spec_res = oss_pkg::F_DNAN;
          else if (a_inf || b_zero) spec_res = {sx, 8'hFF, 23'd0};
          else if (b_inf || a_zero) spec_res = {sx, 31'd0};
          else spec = 1'b0;
        end
        default: spec = 1'b1;
      endcase
    end

    a_big   = (eau > ebu) || ((eau == ebu) && (ma >= mb));
    e_big   = a_big ? eau : ebu;
    e_sm    = a_big ? ebu : eau;
    m_big   = a_big ? ma : mb;
    m_sm    = a_big ? mb : ma;
    s_big   = a_big ? sa : sb;
    s_sm    = a_big ? sb : sa;
    dexp    = e_big - e_sm;
    sm_ext  = {m_sm, 3'b000};
    if (dexp >= 12'sd27) begin
      sm_sh   = 27'd0;
      sm_mask = '1;
    end else begin
      sm_sh   = sm_ext >> dexp[4:0];
      sm_mask = (27'd1 << dexp[4:0]) - 27'd1;
    end
    sm_lost = |(sm_ext & sm_mask);
    sm_jam  = {sm_sh[26:1], sm_sh[0] | sm_lost};
    sum28   = (s_big == s_sm) ? ({1'b0, m_big, 3'b000} + {1'b0, sm_jam})
                              : ({1'b0, m_big, 3'b000} - {1'b0, sm_jam});
    prod    = ma * mb;

    trial   = {1'b0, rem_q} - {3'd0, mb_q};
    qbit    = !trial[26];
    nrem    = qbit ? trial[25:0] : rem_q;

    biased  = e_q + 12'sd176;
    expf    = r_q[49] ? biased[7:0] : 8'd0;
    base    = {expf, r_q[48:26]};
    inc     = r_q[25] & (r_q[26] | (|r_q[24:0]) | stk_q);
  end

  always_comb begin
    st_d   = st_q;
    done_d = 1'b0;
    res_d  = res_q;
    sgn_d  = sgn_q;
    ea_d   = ea_q;
    eb_d   = eb_q;
    e_d    = e_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    rem_d  = rem_q;
    r_d    = r_q;
    stk_d  = stk_q;
    cnt_d  = cnt_q;
    unique case (st_q)
      S_IDLE: begin
        if (req_i.start) begin
          stk_d = 1'b0;
          if (spec) begin
            res_d  = spec_res;
            done_d = 1'b1;
          end else begin
            unique case (req_i.op)
              oss_pkg::OP_ADD, oss_pkg::OP_SUB: begin
                if (sum28 == 28'd0) begin
                  res_d  = oss_pkg::F_ZERO;
                  done_d = 1'b1;
                end else begin
                  sgn_d = s_big;
                  r_d   = {sum28, 22'd0};
                  e_d   = e_big - 12'sd25;
                  st_d  = S_NORM;
                end
              end
              oss_pkg::OP_MUL: begin
                sgn_d = sx;
                r_d   = {prod, 2'b00};
                e_d   = eau + ebu - 12'sd2;
                st_d  = S_NORM;
              end
              default: begin
                sgn_d = sx;
                ma_d  = ma;
                mb_d  = mb;
                ea_d  = eau;
                eb_d  = ebu;
                st_d  = S_PRE;
              end
            endcase
          end
        end
      end
      S_PRE: begin
        if (!ma_q[23]) begin
          ma_d = {ma_q[22:0], 1'b0};
          ea_d = ea_q - 12'sd1;
        end else if (!mb_q[23]) begin
          mb_d = {mb_q[22:0], 1'b0};
          eb_d = eb_q - 12'sd1;
        end else begin
          rem_d = {2'b00, ma_q};
          r_d   = '0;
          cnt_d = 5'd0;
          st_d  = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = {nrem[24:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        r_d   = {r_q[48:0], qbit};
        if (cnt_q == 5'd26) begin
          r_d   = {r_q[25:0], qbit, 23'd0};
          stk_d = (nrem != 26'd0);
          e_d   = ea_q - eb_q - 12'sd49;
          st_d  = S_NORM;
        end
      end
      S_NORM: begin
        if (r_q[49]) begin
          st_d = (biased >= 12'sd1) ? S_PACK : S_DEN;
        end else begin
          r_d = {r_q[48:0], 1'b0};
          e_d = e_q - 12'sd1;
        end
      end
      S_DEN: begin
        if (biased >= 12'sd1) begin
          st_d = S_PACK;
        end else if (biased < -12'sd30) begin
          stk_d = stk_q | (|r_q);
          r_d   = '0;
          e_d   = -12'sd175;
          st_d  = S_PACK;
        end else begin
          stk_d = stk_q | r_q[0];
          r_d   = {1'b0, r_q[49:1]};
          e_d   = e_q + 12'sd1;
        end
      end
      S_PACK: begin
        if (biased >= 12'sd255) begin
          res_d = {sgn_q, 8'hFF, 23'd0};
        end else begin
          res_d = {sgn_q, base + {30'd0, inc}};
        end
        done_d = 1'b1;
        st_d   = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    sgn_q <= sgn_d;
    ea_q  <= ea_d;
    eb_q  <= eb_d;
    e_q   <= e_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    rem_q <= rem_d;
    r_q   <= r_d;
    stk_q <= stk_d;
    cnt_q <= cnt_d;
  end

  assign rsp_o = '{done: done_q, res: res_q};

endmodule
`default_nettype wire

// ----- rtl/omega_statistic_stream_core.sv -----
// Top level of the omega statistic stream core: sequencer, operands and totals.
// Each item runs sixteen float32 operations in a fixed order through one shared
// iterative unit, then updates the running maximum, minimum and sum. A divide
// yields one quotient bit per cycle, and each item holds five divides. An
// operation on a zero, infinity or NaN operand skips the iterative states.
// Subnormal values add extra normalize steps. The input is ready only while the
// core is idle. A finished result waits in an output register until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module omega_statistic_stream_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire oss_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output oss_pkg::out_t      out_data_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]        st_q, st_d;
  logic [3:0]        step_q, step_d;
  oss_pkg::in_t      in_q, in_d;
  logic [31:0]       t0_q, t0_d, t1_q, t1_d, t2_q, t2_d;
  logic [31:0]       sum_q, sum_d, max_q, max_d, min_q, min_d;
  oss_pkg::out_t     out_q, out_d;
  logic              out_valid_q, out_valid_d;

  oss_pkg::step_t    stp;
  oss_pkg::fpu_req_t req;
  oss_pkg::fpu_rsp_t rsp;
  logic [31:0]       new_max, new_min;

  function automatic logic [31:0] pick(input logic [3:0] sel, input oss_pkg::in_t d,
                                       input logic [31:0] t0, input logic [31:0] t1,
                                       input logic [31:0] t2, input logic [31:0] s);
    logic [31:0] v;
    unique case (sel)
      oss_pkg::SRC_M:    v = d.m_value;
      oss_pkg::SRC_N:    v = d.n_value;
      oss_pkg::SRC_L:    v = d.left_sum;
      oss_pkg::SRC_R:    v = d.right_sum;
      oss_pkg::SRC_C:    v = d.total_sum;
      oss_pkg::SRC_ONE:  v = oss_pkg::F_ONE;
      oss_pkg::SRC_TWO:  v = oss_pkg::F_TWO;
      oss_pkg::SRC_BIAS: v = oss_pkg::F_BIAS;
      oss_pkg::SRC_SUM:  v = s;
      oss_pkg::SRC_T0:   v = t0;
      oss_pkg::SRC_T1:   v = t1;
      oss_pkg::SRC_T2:   v = t2;
      default:           v = oss_pkg::F_ZERO;
    endcase
    return v;
  endfunction

  oss_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_comb begin
    stp       = oss_pkg::step_cfg(step_q);
    req.start = (st_q == ST_ISSUE);
    req.op    = stp.op;
    req.a     = pick(stp.a_sel, in_q, t0_q, t1_q, t2_q, sum_q);
    req.b     = pick(stp.b_sel, in_q, t0_q, t1_q, t2_q, sum_q);
    new_max   = oss_pkg::f_gt(t0_q, max_q) ? t0_q : max_q;
    new_min   = oss_pkg::f_gt(min_q, t0_q) ? t0_q : min_q;

    st_d        = st_q;
    step_d      = step_q;
    in_d        = in_q;
    t0_d        = t0_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    sum_d       = sum_q;
    max_d       = max_q;
    min_d       = min_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_d   = in_data_i;
          step_d = 4'd0;
          st_d   = ST_ISSUE;
        end
      end
      ST_ISSUE: st_d = ST_WAIT;
      ST_WAIT: begin
        if (rsp.done) begin
          unique case (stp.dst)
            oss_pkg::DST_T0:  t0_d  = rsp.res;
            oss_pkg::DST_T1:  t1_d  = rsp.res;
            oss_pkg::DST_T2:  t2_d  = rsp.res;
            oss_pkg::DST_SUM: sum_d = rsp.res;
            default:          t0_d  = rsp.res;
          endcase
          if (step_q == 4'(oss_pkg::NumSteps - 1)) begin
            st_d = ST_FIN;
          end else begin
            step_d = step_q + 4'd1;
            st_d   = ST_ISSUE;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.omega_value = t0_q;
          if (in_q.last) begin
            out_d.max_value    = new_max;
            out_d.min_value    = new_min;
            out_d.sum_value    = sum_q;
            out_d.totals_valid = 1'b1;
            max_d              = oss_pkg::F_ZERO;
            min_d              = oss_pkg::F_MAX;
            sum_d              = oss_pkg::F_ZERO;
          end else begin
            out_d.max_value    = oss_pkg::F_ZERO;
            out_d.min_value    = oss_pkg::F_ZERO;
            out_d.sum_value    = oss_pkg::F_ZERO;
            out_d.totals_valid = 1'b0;
            max_d              = new_max;
            min_d              = new_min;
          end
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      step_q      <= 4'd0;
      out_valid_q <= 1'b0;
      sum_q       <= oss_pkg::F_ZERO;
      max_q       <= oss_pkg::F_ZERO;
      min_q       <= oss_pkg::F_MAX;
    end else begin
      st_q        <= st_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
      max_q       <= max_d;
      min_q       <= min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    t0_q  <= t0_d;
    t1_q  <= t1_d;
    t2_q  <= t2_d;
    out_q <= out_d;
  end

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ----- rtl/oss_checker.sv -----
// Port-level checks for the omega stream core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module oss_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire oss_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted item");

  a_totals_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.totals_valid |->
      (out_data_o.max_value == 32'd0) && (out_data_o.min_value == 32'd0) &&
      (out_data_o.sum_value == 32'd0))
    else $error("totals shown on an item not marked last");

endmodule

bind omega_statistic_stream_core oss_checker u_oss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

// ----- verif/tb_omega_statistic_stream_core.sv -----
// Testbench for omega_statistic_stream_core: random and directed items checked against a float32 predictor.
`timescale 1ns / 1ps
module tb_omega_statistic_stream_core;
  import oss_pkg::*;

  localparam int unsigned RandItems  = 1200;
  localparam longint      CycleLimit = 3_000_000;

  class omega_scoreboard;
    out_t        pending_q[$];
    logic [31:0] set_max;
    logic [31:0] set_min;
    logic [31:0] set_sum;
    int unsigned errors;

    function new();
      errors = 0;
      clear_totals();
    endfunction

    function void clear_totals();
      set_max = F_ZERO;
      set_min = F_MAX;
      set_sum = F_ZERO;
    endfunction

    function bit is_nan(logic [31:0] x);
      return (&x[30:23]) && (|x[22:0]);
    endfunction

    function bit is_inf(logic [31:0] x);
      return (&x[30:23]) && !(|x[22:0]);
    endfunction

    function bit is_zero(logic [31:0] x);
      return x[30:0] == 31'd0;
    endfunction

    function logic [31:0] quiet_of(logic [31:0] a, logic [31:0] b);
      return is_nan(a) ? (a | F_QBIT) : (b | F_QBIT);
    endfunction

    function void split(input logic [31:0] x, output logic [63:0] sig, output int ex);
      if (x[30:23] == 8'd0) begin
        sig = {41'd0, x[22:0]};
        ex  = -149;
      end else begin
        sig = {40'd0, 1'b1, x[22:0]};
        ex  = int'(x[30:23]) - 150;
      end
      while (!sig[23]) begin
        sig = sig << 1;
        ex  = ex - 1;
      end
    endfunction

    function logic [31:0] round_pack(bit s, logic [63:0] sig, int ex);
      int          top;
      int          sh;
      int          q;
      int          ef;
      logic [63:0] kept;
      logic [63:0] rem;
      logic [63:0] half;
      if (sig == 64'd0) return {s, 31'd0};
      top = 63;
      while (!sig[top]) top--;
      sh = top - 23;
      if (-149 - ex > sh) sh = -149 - ex;
      if (sh > 64) begin
        kept = 64'd0;
      end else if (sh == 64) begin
        kept = (sig > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
      end else if (sh > 0) begin
        kept = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
      end else begin
        kept = sig << (-sh);
      end
      q = ex + sh;
      if (kept[24]) begin
        kept = kept >> 1;
        q    = q + 1;
      end
      if (kept == 64'd0) return {s, 31'd0};
      if (!kept[23]) return {s, 8'd0, kept[22:0]};
      ef = q + 150;
      if (ef >= 255) return {s, 8'hFF, 23'd0};
      return {s, ef[7:0], kept[22:0]};
    endfunction

    function logic [31:0] add_signed(logic [31:0] a, logic [31:0] b);
      logic [63:0] sa;
      logic [63:0] sb;
      logic [63:0] big;
      logic [63:0] lit;
      int          ea;
      int          eb;
      int          d;
      int          ex;
      bit          sbig;
      bit          slit;
      if (is_inf(a)) return (is_inf(b) && a[31] != b[31]) ? F_DNAN : a;
      if (is_inf(b)) return b;
      if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
      if (is_zero(a)) return b;
      if (is_zero(b)) return a;
      split(a, sa, ea);
      split(b, sb, eb);
      if (ea >= eb) begin
        big = sa; lit = sb; sbig = a[31]; slit = b[31]; d = ea - eb; ex = eb;
      end else begin
        big = sb; lit = sa; sbig = b[31]; slit = a[31]; d = eb - ea; ex = ea;
      end
      if (d <= 36) begin
        big = big << d;
      end else begin
        ex  = ex + d - 36;
        big = big << 36;
        if (d - 36 >= 24) lit = 64'd1;
        else lit = (lit >> (d - 36)) | ((lit & ((64'd1 << (d - 36)) - 64'd1)) != 0);
      end
      if (sbig == slit) return round_pack(sbig, big + lit, ex);
      if (big == lit) return F_ZERO;
      if (big > lit) return round_pack(sbig, big - lit, ex);
      return round_pack(slit, lit - big, ex);
    endfunction

    function logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
      if (is_nan(a) || is_nan(b)) return quiet_of(a, b);
      return add_signed(a, b);
    endfunction

    function logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
      if (is_nan(a) || is_nan(b)) return quiet_of(a, b);
      return add_signed(a, b ^ 32'h8000_0000);
    endfunction

    function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
      logic [63:0] sa;
      logic [63:0] sb;
      int          ea;
      int          eb;
      bit          s;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return quiet_of(a, b);
      if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return F_DNAN;
      if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
      if (is_zero(a) || is_zero(b)) return {s, 31'd0};
      split(a, sa, ea);
      split(b, sb, eb);
      return round_pack(s, sa * sb, ea + eb);
    endfunction

    function logic [31:0] fdiv(logic [31:0] a, logic [31:0] b);
      logic [63:0] sa;
      logic [63:0] sb;
      logic [63:0] quo;
      logic [63:0] rem;
      int          ea;
      int          eb;
      bit          s;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return quiet_of(a, b);
      if ((is_inf(a) && is_inf(b)) || (is_zero(a) && is_zero(b))) return F_DNAN;
      if (is_inf(a) || is_zero(b)) return {s, 8'hFF, 23'd0};
      if (is_inf(b) || is_zero(a)) return {s, 31'd0};
      split(a, sa, ea);
      split(b, sb, eb);
      quo = (sa << 40) / sb;
      rem = (sa << 40) % sb;
      return round_pack(s, (quo << 1) | (rem != 0), ea - eb - 41);
    endfunction

    function bit fgt(logic [31:0] a, logic [31:0] b);
      logic [31:0] ka;
      logic [31:0] kb;
      if (is_nan(a) || is_nan(b) || (is_zero(a) && is_zero(b))) return 1'b0;
      ka = a[31] ? ~a : (a | 32'h8000_0000);
      kb = b[31] ? ~b : (b | 32'h8000_0000);
      return ka > kb;
    endfunction

    function logic [31:0] omega_of(in_t d);
      logic [31:0] lr;
      logic [31:0] qm;
      logic [31:0] qn;
      logic [31:0] num;
      logic [31:0] den;
      lr  = fadd(d.left_sum, d.right_sum);
      qm  = fdiv(fmul(d.m_value, fsub(d.m_value, F_ONE)), F_TWO);
      qn  = fdiv(fmul(d.n_value, fsub(d.n_value, F_ONE)), F_TWO);
      num = fdiv(lr, fadd(qm, qn));
      den = fdiv(fsub(fsub(d.total_sum, d.left_sum), d.right_sum),
                 fmul(d.m_value, d.n_value));
      return fdiv(num, fadd(den, F_BIAS));
    endfunction

    function void note_input(in_t d);
      out_t        o;
      logic [31:0] f;
      f = omega_of(d);
      if (fgt(f, set_max)) set_max = f;
      if (fgt(set_min, f)) set_min = f;
      set_sum = fadd(f, set_sum);
      o = '0;
      o.omega_value = f;
      if (d.last) begin
        o.max_value    = set_max;
        o.min_value    = set_min;
        o.sum_value    = set_sum;
        o.totals_valid = 1'b1;
        clear_totals();
      end
      pending_q.push_back(o);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %08h expected %08h at %0t", what, got, want, $time);
      errors++;
    endfunction

    function void check_result(out_t o);
      out_t w;
      if (pending_q.size() == 0) begin
        report("unexpected item", o.omega_value, 32'd0);
        return;
      end
      w = pending_q.pop_front();
      if (o.omega_value !== w.omega_value) report("omega", o.omega_value, w.omega_value);
      if (o.max_value !== w.max_value) report("max", o.max_value, w.max_value);
      if (o.min_value !== w.min_value) report("min", o.min_value, w.min_value);
      if (o.sum_value !== w.sum_value) report("sum", o.sum_value, w.sum_value);
      if (o.totals_valid !== w.totals_valid)
        report("totals_valid", 32'(o.totals_valid), 32'(w.totals_valid));
    endfunction
  endclass

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  in_t   in_data_i;
  logic  out_valid_o;
  logic  out_ready_i;
  out_t  out_data_o;

  omega_scoreboard omega_sb;
  longint          cycle_cnt;
  int              recv_wait;
  bit              no_idle;

  omega_statistic_stream_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic logic [31:0] count_value(int unsigned k);
    return omega_sb.round_pack(1'b0, 64'(k), 0);
  endfunction

  function automatic logic [31:0] ld_value();
    return {1'b0, 8'($urandom_range(105, 140)), 23'($urandom)};
  endfunction

  function automatic logic [31:0] maybe_noise(logic [31:0] v);
    return ($urandom_range(0, 19) == 0) ? 32'($urandom) : v;
  endfunction

  function automatic in_t window_item(bit last);
    in_t d;
    d.m_value   = maybe_noise(count_value($urandom_range(0, 300)));
    d.n_value   = maybe_noise(count_value($urandom_range(0, 300)));
    d.left_sum  = maybe_noise(ld_value());
    d.right_sum = maybe_noise(ld_value());
    d.total_sum = maybe_noise(omega_sb.fadd(omega_sb.fadd(d.left_sum, d.right_sum),
                                            ld_value()));
    d.last      = last;
    return d;
  endfunction

  task automatic send_item(in_t d);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    omega_sb.note_input(d);
  endtask

  task automatic send_directed(logic [31:0] m, logic [31:0] n, logic [31:0] l,
                               logic [31:0] r, logic [31:0] c, bit last);
    in_t d;
    d = '{m, n, l, r, c, last};
    send_item(d);
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      omega_sb.check_result(out_data_o);
      recv_wait = draw_gap();
      out_ready_i <= (recv_wait == 0);
    end else if (recv_wait > 0) begin
      recv_wait   = recv_wait - 1;
      out_ready_i <= (recv_wait == 0);
    end
  end

  initial begin
    logic [31:0] c3;
    logic [31:0] c10;
    omega_sb    = new();
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b1;
    cycle_cnt   = 0;
    recv_wait   = 0;
    no_idle     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    c3  = count_value(3);
    c10 = count_value(10);
    send_directed(c10, c10, 32'h4120_0000, 32'h4100_0000, 32'h41F0_0000, 1'b0);
    send_directed(F_ZERO, F_ZERO, F_ONE, F_ONE, F_TWO, 1'b0);
    send_directed(F_ONE, F_ONE, F_ONE, F_ONE, F_TWO, 1'b0);
    send_directed(c3, c3, 32'h7F80_0001, F_ONE, c10, 1'b0);
    send_directed(32'hFFC1_2345, c3, F_ONE, F_ONE, c10, 1'b1);
    send_directed(c3, c3, F_ONE, F_ONE, 32'h7F80_0000, 1'b0);
    send_directed(c3, c3, F_ONE, F_ONE, 32'hFF80_0000, 1'b0);
    send_directed(c3, c3, 32'h7F80_0000, 32'hFF80_0000, c10, 1'b1);
    send_directed(c3, c3, 32'hBF80_0000, F_ZERO, F_ZERO, 1'b1);
    send_directed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 1'b0);
    send_directed(F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO, 1'b1);
    send_directed(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                  32'h0000_0003, 1'b0);
    send_directed(F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, 1'b0);
    send_directed(32'h0080_0000, c10, 32'h007F_FFFF, 32'h8000_0001, F_ONE, 1'b0);
    send_directed(c10, c10, 32'h3F80_0000, F_ZERO, 32'hC1A0_0000, 1'b0);
    send_directed(c3, c3, 32'hC000_0000, F_ZERO, 32'h3F00_0000, 1'b1);
    send_directed(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, F_ZERO, F_ZERO, 1'b0);
    send_directed(c3, c10, 32'h0000_0000, 32'h0000_0000, 32'h4000_0000, 1'b1);
    for (int i = 0; i < RandItems; i++) begin
      if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0)
        send_item(in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom)}));
      else
        send_item(window_item($urandom_range(0, 9) == 0));
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b0;
    while (omega_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (omega_sb.errors == 0 && omega_sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/oss_pkg.sv
rtl/oss_fpu.sv
rtl/omega_statistic_stream_core.sv
rtl/oss_checker.sv
verif/tb_omega_statistic_stream_core.sv
